[rtl/brb_pkg.sv]
package brb_pkg;

   // field widths of the request and response words
   localparam int LANES      = 4;
   localparam int LANE_W     = 2;
   localparam int COUNT_W    = 3;
   localparam int BYTE_W     = 8;
   localparam int AVAIL_W    = 10;
   localparam int RING_W     = 11;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 56;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register selects, taken from the word address bit
   localparam logic REG_RING_SIZE = 1'b0;

   localparam logic [RING_W-1:0] RING_RESET = 11'd1024;

   // request kinds
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic step;
      logic publish;
   } ctl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic steps_done;
      logic out_free;
   } ctl_stat_type;

endpackage

[rtl/byte_ring_buffer_unit.sv]
// channel   | direction | handshake              | payload
// req_      | in        | req_tvalid/req_tready  | tdata burst count + 4 bytes, tuser opcode
// rsp_      | out       | rsp_tvalid/rsp_tready  | tdata count, 4 read bytes, fill, room
// csr_      | in        | APB psel/penable       | ring_size at byte address 0
//
// One request is worked on at a time: after acceptance the controller steps one
// byte a cycle through the single write and single read port of the byte store,
// then loads the response register; the next request is taken in the cycle after that.
// A new request is taken while the previous response still waits on rsp_tready;
// only loading the next response stalls until that one is taken.
// Reset (synchronous) empties the ring and sets ring_size to 1024; the store
// itself is not cleared. Writing ring_size empties the ring.
module byte_ring_buffer_unit #(
   parameter int STORE_DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // burst_count[2:0], write_byte_0[10:3], write_byte_1[18:11],
   // write_byte_2[26:19], write_byte_3[34:27], zero fill
   input  logic [brb_pkg::REQ_DATA_W-1:0]      req_tdata,
   // opcode
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // moved_count[2:0], read_byte_0[10:3], read_byte_1[18:11], read_byte_2[26:19],
   // read_byte_3[34:27], readable_bytes[44:35], writable_bytes[54:45], zero fill
   output logic [brb_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [brb_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [brb_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [brb_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   import brb_pkg::*;

   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   assign csr_pready = 1'b1;

   brb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   brb_datapath #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

[rtl/brb_ram.sv]
module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/brb_ctrl.sv]
module brb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output brb_pkg::ctl_cmd_type  cmd,
   input  brb_pkg::ctl_stat_type stat
);

   import brb_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_STEP   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (stat.steps_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_FINISH: begin
            // wait for the response register to free up
            if (stat.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_load_starts_steps: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_STEP)
      else $error("load did not enter the byte stepping state");

   a_finish_after_steps: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |-> stat.steps_done)
      else $error("finish reached with bytes still to move");

endmodule

[rtl/brb_datapath.sv]
module brb_datapath #(
   parameter int STORE_DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [brb_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [brb_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [brb_pkg::CSR_DATA_W-1:0]   csr_prdata,
   input  logic [brb_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [brb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  brb_pkg::ctl_cmd_type             cmd,
   output brb_pkg::ctl_stat_type            stat
);

   import brb_pkg::*;

   localparam int IW = $clog2(STORE_DEPTH);
   localparam int SW = $clog2(STORE_DEPTH + 1);
   localparam int CW = (SW > RING_W) ? SW : RING_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

   logic [RING_W-1:0]  ring_size_ff, ring_size_in;
   logic [IW-1:0]      wr_idx_ff, wr_idx_in;
   logic [IW-1:0]      rd_idx_ff, rd_idx_in;
   logic               op_ff;
   logic [COUNT_W-1:0] moved_ff;
   logic [COUNT_W-1:0] step_ff, step_in;
   logic [BYTE_W-1:0]  wbyte_ff [LANES];
   logic [BYTE_W-1:0]  got_ff [LANES];
   logic               rd_pend_ff;
   logic [LANE_W-1:0]  rd_lane_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic               cfg_wr;
   logic [CW-1:0]      ring_ext;
   logic [SW-1:0]      eff_size;
   logic [SW-1:0]      readable;
   logic [SW-1:0]      writable;
   logic [CW-1:0]      avail;
   logic [COUNT_W-1:0] burst_clip;
   logic [COUNT_W-1:0] moved_calc;
   logic [SW-1:0]      wr_next;
   logic [SW-1:0]      rd_next;
   logic               mem_wr_en;
   logic [BYTE_W-1:0]  mem_rd_data;
   logic [RSP_DATA_W-1:0] rsp_pack;

   // register write and readback
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite & (csr_paddr[2] == REG_RING_SIZE);
   assign csr_prdata = (csr_paddr[2] == REG_RING_SIZE) ? CSR_DATA_W'(ring_size_ff) : '0;
   assign ring_size_in = cfg_wr ? csr_pwdata[RING_W-1:0] : ring_size_ff;

   // clamp the ring size to the range from 2 up to the store depth
   always_comb begin
      ring_ext = CW'(ring_size_ff);
      priority if (ring_ext < CW'(2)) begin
         eff_size = SW'(2);
      end else if (ring_ext > DEPTH_C) begin
         eff_size = SW'(STORE_DEPTH);
      end else begin
         eff_size = SW'(ring_ext);
      end
   end

   // fill level and free room
   assign readable = (wr_idx_ff >= rd_idx_ff) ? (SW'(wr_idx_ff) - SW'(rd_idx_ff))
                                              : (eff_size - (SW'(rd_idx_ff) - SW'(wr_idx_ff)));
   assign writable = eff_size - SW'(1) - readable;

   // cut the burst down to the four lanes and to what the ring allows
   assign burst_clip = (req_tdata[COUNT_W-1:0] > COUNT_W'(LANES)) ? COUNT_W'(LANES)
                                                                 : req_tdata[COUNT_W-1:0];
   assign avail      = (req_tuser == OP_READ) ? CW'(readable) : CW'(writable);
   assign moved_calc = (CW'(burst_clip) > avail) ? COUNT_W'(avail) : burst_clip;

   assign stat.steps_done = (step_ff == moved_ff);
   assign stat.out_free   = ~rsp_valid_ff | rsp_tready;

   // index advance with wrap at the ring size
   assign wr_next = SW'(wr_idx_ff) + SW'(1);
   assign rd_next = SW'(rd_idx_ff) + SW'(1);

   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      step_in   = step_ff;
      mem_wr_en = 1'b0;
      if (cfg_wr) begin
         wr_idx_in = '0;
         rd_idx_in = '0;
      end else if (cmd.load) begin
         step_in = '0;
      end else if (cmd.step) begin
         step_in = step_ff + COUNT_W'(1);
         if (op_ff == OP_WRITE) begin
            mem_wr_en = 1'b1;
            wr_idx_in = (wr_next >= eff_size) ? '0 : wr_next[IW-1:0];
         end else begin
            rd_idx_in = (rd_next >= eff_size) ? '0 : rd_next[IW-1:0];
         end
      end
   end

   brb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wr_idx_ff),
      .wr_data (wbyte_ff[step_ff[LANE_W-1:0]]),
      .rd_addr (rd_idx_ff),
      .rd_data (mem_rd_data)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_size_ff <= RING_RESET;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         step_ff      <= '0;
         moved_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ring_size_ff <= ring_size_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         step_ff      <= step_in;
         if (cmd.load) begin
            moved_ff <= moved_calc;
         end
         rd_pend_ff   <= cmd.step & (op_ff == OP_READ);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid_in = cmd.publish | (rsp_valid_ff & ~rsp_tready);

   // payload: latch the request, collect each read byte in the cycle after its read
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_tuser;
         for (int i = 0; i < LANES; i++) begin
            wbyte_ff[i] <= req_tdata[COUNT_W + i*BYTE_W +: BYTE_W];
            got_ff[i]   <= '0;
         end
      end else if (rd_pend_ff) begin
         got_ff[rd_lane_ff] <= mem_rd_data;
      end
      rd_lane_ff <= step_ff[LANE_W-1:0];
      if (cmd.publish) begin
         rsp_data_ff <= rsp_pack;
      end
   end

   // pack the response word
   always_comb begin
      rsp_pack = '0;
      rsp_pack[COUNT_W-1:0] = moved_ff;
      for (int i = 0; i < LANES; i++) begin
         rsp_pack[COUNT_W + i*BYTE_W +: BYTE_W] = got_ff[i];
      end
      rsp_pack[COUNT_W + LANES*BYTE_W +: AVAIL_W]           = AVAIL_W'(readable);
      rsp_pack[COUNT_W + LANES*BYTE_W + AVAIL_W +: AVAIL_W] = AVAIL_W'(writable);
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_step_bounded: assert property (@(posedge clock) disable iff (reset)
      step_ff <= moved_ff || $past(cmd.load) == 1'b0 && step_ff == '0)
      else $error("byte step counter ran past the moved count");

   a_read_follows_read_op: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> $past(op_ff) == OP_READ && $past(cmd.step))
      else $error("read byte captured without a read step");

endmodule
